FILE: sv/lcbc_pkg.sv
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared types, mode codes and constants for the LED color blend compositor.
// ----------------------------------------------------------------------------
package lcbc_pkg;

    // One pixel: channel 0 is red (bits 7:0), 1 green, 2 blue
    localparam int unsigned CH_N  = 3;
    localparam int unsigned CH_W  = 8;
    localparam int unsigned SUM_W = 10;   // sum of three channels, 0..765
    localparam int unsigned NUM_W = 18;   // lerp numerator, 0..195075

    typedef logic [CH_N-1:0][CH_W-1:0] pixel_t;
    typedef logic [CH_W-1:0]           chan_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLEND_MODE = 2'd0;
    localparam logic [1:0] CFG_MIX_MODE   = 2'd1;
    localparam logic [1:0] CFG_PRIMARY    = 2'd2;
    localparam logic [1:0] CFG_SECONDARY  = 2'd3;

    // Source transform codes
    localparam logic [1:0] BLEND_NONE   = 2'd0;
    localparam logic [1:0] BLEND_INVERT = 2'd1;
    localparam logic [1:0] BLEND_THRESH = 2'd2;
    localparam logic [1:0] BLEND_LERP   = 2'd3;

    // Combine codes; the unused code acts as replace
    localparam logic [2:0] MIX_MAX     = 3'd0;
    localparam logic [2:0] MIX_MIN     = 3'd1;
    localparam logic [2:0] MIX_AVG     = 3'd2;
    localparam logic [2:0] MIX_MUL     = 3'd3;
    localparam logic [2:0] MIX_ADD     = 3'd4;
    localparam logic [2:0] MIX_SUB     = 3'd5;
    localparam logic [2:0] MIX_REPLACE = 3'd6;

    // Threshold compare: 2*sum < 765
    localparam logic [SUM_W:0] THRESH_LIMIT = 11'd765;

    // Lerp full scale
    localparam logic [SUM_W-1:0] LERP_SCALE = 10'd765;

    // floor(n/765) = (n * DIV_MULT) >> DIV_SHIFT, exact for n < 2^18
    localparam int unsigned       DIV_MULT_W = 19;
    localparam logic [18:0]       DIV_MULT   = 19'd350897;
    localparam int unsigned       DIV_SHIFT  = 28;

endpackage

FILE: sv/led_color_blend_compositor.sv
// ----------------------------------------------------------------------------
// led_color_blend_compositor
// Transforms a source pixel by blend mode and composites it onto a target.
// ----------------------------------------------------------------------------
// One pixel beat is taken on every clock at which start is high; busy is
// always low, so the block runs at one pixel per clock. Each result appears on
// blended_pixel with done high for one cycle, once it has passed stage registers
// A to E, in order; the receiver cannot stall and the pipeline never holds.
// The five stages are: input capture, channel sum and simple transforms,
// lerp numerator multiply, divide by 765 via reciprocal multiply, and the
// channel mix with its 8x8 multiply. Write configuration only while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module led_color_blend_compositor
    import lcbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [23:0] target_pixel,
    input  logic [23:0] source_pixel,
    output logic        done,
    output logic [23:0] blended_pixel
);

    // Configuration registers
    logic [1:0] blend_mode_reg;
    logic [2:0] mix_mode_reg;
    pixel_t     primary_reg;
    pixel_t     secondary_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= BLEND_NONE;
            mix_mode_reg   <= MIX_REPLACE;
            primary_reg    <= '0;
            secondary_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BLEND_MODE: blend_mode_reg <= cfg_data[1:0];
                CFG_MIX_MODE:   mix_mode_reg   <= cfg_data[2:0];
                CFG_PRIMARY:    primary_reg    <= cfg_data;
                CFG_SECONDARY:  secondary_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: capture the beat
    logic   a_valid_reg;
    pixel_t a_tgt_reg;
    pixel_t a_src_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tgt_reg <= target_pixel;
        a_src_reg <= source_pixel;
    end

    // Stage B: channel sum, zero test, none/invert/threshold transforms
    logic [SUM_W-1:0] b_sum_next;
    logic             b_zero;
    pixel_t           b_xs_next;
    logic             b_lerp_next;

    assign b_sum_next = {2'b00, a_src_reg[0]} + {2'b00, a_src_reg[1]}
                        + {2'b00, a_src_reg[2]};
    assign b_zero     = (a_src_reg == '0);
    assign b_lerp_next = (blend_mode_reg == BLEND_LERP) && !b_zero;

    always_comb
    begin
        unique case (blend_mode_reg)
            BLEND_NONE:   b_xs_next = a_src_reg;
            BLEND_INVERT: b_xs_next = b_zero ? '0 : ~a_src_reg;
            BLEND_THRESH:
            begin
                if (b_zero)
                begin
                    b_xs_next = '0;
                end
                else if ({b_sum_next, 1'b0} < THRESH_LIMIT)
                begin
                    b_xs_next = primary_reg;
                end
                else
                begin
                    b_xs_next = secondary_reg;
                end
            end
            default:      b_xs_next = '0;
        endcase
    end

    logic             b_valid_reg;
    logic [SUM_W-1:0] b_sum_reg;
    pixel_t           b_xs_reg;
    logic             b_lerp_reg;
    pixel_t           b_tgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_sum_reg  <= b_sum_next;
        b_xs_reg   <= b_xs_next;
        b_lerp_reg <= b_lerp_next;
        b_tgt_reg  <= a_tgt_reg;
    end

    // Stage C: lerp numerator p*765 + (s-p)*sum per channel, never negative
    logic [CH_N-1:0][NUM_W-1:0] c_num_next;

    for (genvar k = 0; k < CH_N; k++) begin : g_num
        logic signed [CH_W:0]          diff;
        logic signed [SUM_W:0]         sum_s;
        logic signed [CH_W+SUM_W+1:0]  prod;
        logic        [CH_W+SUM_W-1:0]  base;
        logic signed [CH_W+SUM_W+1:0]  num;

        assign diff  = $signed({1'b0, secondary_reg[k]}) - $signed({1'b0, primary_reg[k]});
        assign sum_s = $signed({1'b0, b_sum_reg});
        assign prod  = (CH_W+SUM_W+2)'(diff * sum_s);
        assign base  = primary_reg[k] * LERP_SCALE;
        assign num   = $signed({2'b00, base}) + prod;
        assign c_num_next[k] = num[NUM_W-1:0];
    end

    logic                       c_valid_reg;
    logic [CH_N-1:0][NUM_W-1:0] c_num_reg;
    pixel_t                     c_xs_reg;
    logic                       c_lerp_reg;
    pixel_t                     c_tgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_num_reg  <= c_num_next;
        c_xs_reg   <= b_xs_reg;
        c_lerp_reg <= b_lerp_reg;
        c_tgt_reg  <= b_tgt_reg;
    end

    // Stage D: divide by 765 with an exact reciprocal, pick the source
    pixel_t d_quot;
    pixel_t d_src_next;

    for (genvar k = 0; k < CH_N; k++) begin : g_div
        logic [NUM_W+DIV_MULT_W-1:0] prod;

        assign prod      = c_num_reg[k] * DIV_MULT;
        assign d_quot[k] = prod[DIV_SHIFT+CH_W-1:DIV_SHIFT];
    end

    assign d_src_next = c_lerp_reg ? d_quot : c_xs_reg;

    logic   d_valid_reg;
    pixel_t d_src_reg;
    pixel_t d_tgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_src_reg <= d_src_next;
        d_tgt_reg <= c_tgt_reg;
    end

    // Stage E: mix and output register
    pixel_t e_mix_next;

    lcbc_mix u_mix (
        .mode  (mix_mode_reg),
        .tgt   (d_tgt_reg),
        .src   (d_src_reg),
        .mixed (e_mix_next)
    );

    logic   e_valid_reg;
    pixel_t e_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_pix_reg <= e_mix_next;
    end

    assign done          = e_valid_reg;
    assign blended_pixel = e_pix_reg;

    // Checks
    // every result beat comes from an earlier start beat
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("result beat without matching start");

    // no start beat is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("start beat lost in pipeline");

    // subtract never raises the red channel above the target
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mix_mode_reg == MIX_SUB))
            |-> (blended_pixel[7:0] <= $past(target_pixel[7:0], 5)))
        else $error("subtract result above target");

    // max never leaves the red channel below the target
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mix_mode_reg == MIX_MAX))
            |-> (blended_pixel[7:0] >= $past(target_pixel[7:0], 5)))
        else $error("max result below target");

endmodule

FILE: sv/lcbc_mix.sv
// ----------------------------------------------------------------------------
// lcbc_mix
// Channel-wise combine of target and transformed source under the mix mode.
// ----------------------------------------------------------------------------
module lcbc_mix
    import lcbc_pkg::*;
(
    input  logic [2:0] mode,
    input  pixel_t     tgt,
    input  pixel_t     src,
    output pixel_t     mixed
);

    pixel_t chan_res;

    // Per-channel arithmetic modes
    for (genvar k = 0; k < CH_N; k++) begin : g_chan
        logic [CH_W:0]     sum_ab;
        logic [2*CH_W-1:0] prod;
        logic [2*CH_W:0]   prod_adj;
        chan_t             a;
        chan_t             b;

        assign a        = tgt[k];
        assign b        = src[k];
        assign sum_ab   = {1'b0, a} + {1'b0, b};
        assign prod     = a * b;
        // floor(x/255) = (x + (x >> 8) + 1) >> 8 for x up to 255*255
        assign prod_adj = {1'b0, prod} + {{(CH_W+1){1'b0}}, prod[2*CH_W-1:CH_W]}
                          + {{(2*CH_W){1'b0}}, 1'b1};

        always_comb
        begin
            unique case (mode)
                MIX_MAX: chan_res[k] = (a > b) ? a : b;
                MIX_MIN: chan_res[k] = (a < b) ? a : b;
                MIX_AVG: chan_res[k] = sum_ab[CH_W:1];
                MIX_MUL: chan_res[k] = prod_adj[2*CH_W-1:CH_W];
                MIX_ADD: chan_res[k] = sum_ab[CH_W] ? {CH_W{1'b1}} : sum_ab[CH_W-1:0];
                default: chan_res[k] = (a > b) ? (a - b) : '0;
            endcase
        end
    end

    // Replace keeps the target where the source is black
    always_comb
    begin
        if (mode >= MIX_REPLACE)
        begin
            mixed = (src != '0) ? src : tgt;
        end
        else
        begin
            mixed = chan_res;
        end
    end

endmodule

FILE: tb/tb_led_color_blend_compositor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_color_blend_compositor
// Self-checking bench for the LED color blend compositor. Pixel beats are
// sent under every blend and mix setting, and each one is predicted in
// the bench. Every blended pixel that comes back is compared, in order,
// with its prediction. A directed part covers the edge cases, then random
// phases each set a fresh configuration and send a burst of pixels.
// ----------------------------------------------------------------------------
module tb_led_color_blend_compositor;

    import lcbc_pkg::*;

    // Spare mix code, decoded like replace
    localparam logic [2:0] MIX_SPARE = 3'd7;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASES       = 21;
    localparam int unsigned PHASE_BEATS  = 50;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = '0;
    logic [23:0] cfg_data     = '0;
    logic        start        = 1'b0;
    logic [23:0] target_pixel = '0;
    logic [23:0] source_pixel = '0;
    logic        busy;
    logic        done;
    logic [23:0] blended_pixel;

    // Shadow copy of the configuration registers (reset values)
    logic [1:0]  cur_blend     = BLEND_NONE;
    logic [2:0]  cur_mix       = MIX_REPLACE;
    pixel_t      cur_primary   = '0;
    pixel_t      cur_secondary = '0;

    pixel_t      expected_pixels[$];
    int          errors     = 0;
    int          n_pixels   = 0;
    int          n_settings = 0;
    int          n_checked  = 0;
    int unsigned cycles     = 0;
    bit          no_gaps    = 1'b0;

    led_color_blend_compositor uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .target_pixel  (target_pixel),
        .source_pixel  (source_pixel),
        .done          (done),
        .blended_pixel (blended_pixel)
    );

    // Clock
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Source transform under the current blend mode
    function automatic pixel_t shade_source(pixel_t src);
        pixel_t shaded;
        int     sum;
        int     num;
        int     p;
        int     s;
        shaded = '0;
        sum = int'(src[0]) + int'(src[1]) + int'(src[2]);
        if (cur_blend == BLEND_NONE)
            shaded = src;
        else if (src == '0)
            shaded = '0;
        else if (cur_blend == BLEND_INVERT)
            shaded = ~src;
        else if (cur_blend == BLEND_THRESH)
            shaded = (2 * sum < 765) ? cur_primary : cur_secondary;
        else
        begin
            // lerp from primary toward secondary, weight sum/765
            for (int k = 0; k < CH_N; k++)
            begin
                p = int'(cur_primary[k]);
                s = int'(cur_secondary[k]);
                num = p * 765 + (s - p) * sum;
                shaded[k] = chan_t'(num / 765);
            end
        end
        return shaded;
    endfunction

    // One channel under the current mix mode (replace handled by caller)
    function automatic chan_t mix_chan(chan_t a, chan_t b);
        int sa;
        int sb;
        int r;
        sa = int'(a);
        sb = int'(b);
        case (cur_mix)
            MIX_MAX: r = (sa > sb) ? sa : sb;
            MIX_MIN: r = (sa < sb) ? sa : sb;
            MIX_AVG: r = (sa + sb) / 2;
            MIX_MUL: r = (sa * sb) / 255;
            MIX_ADD: r = (sa + sb > 255) ? 255 : sa + sb;
            default: r = (sa > sb) ? sa - sb : 0;
        endcase
        return chan_t'(r);
    endfunction

    function automatic pixel_t predict_blend(pixel_t tgt, pixel_t src);
        pixel_t shaded;
        pixel_t res;
        shaded = shade_source(src);
        res = '0;
        if (cur_mix >= MIX_REPLACE)
            res = (shaded != '0) ? shaded : tgt;
        else
            for (int k = 0; k < CH_N; k++)
                res[k] = mix_chan(tgt[k], shaded[k]);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, pixel_t want, pixel_t got);
        errors++;
        $display("[%0t] MISMATCH %s: expected %06h got %06h", $time, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_result
        pixel_t want;
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result with no pending pixel", '0, blended_pixel);
            else
            begin
                want = expected_pixels.pop_front();
                n_checked++;
                if (blended_pixel !== want)
                    report_mismatch("blended_pixel", want, blended_pixel);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one pixel beat; returns at the edge where it was taken
    task automatic send_pixel(input pixel_t tgt, input pixel_t src);
        int     gap;
        pixel_t predicted;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start        <= 1'b0;
            target_pixel <= 24'($urandom);
            source_pixel <= 24'($urandom);
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        target_pixel <= tgt;
        source_pixel <= src;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = predict_blend(tgt, src);
        expected_pixels = {expected_pixels, predicted};
        n_pixels++;
    endtask

    // Drop start and let the pipeline drain
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers once the block is idle
    task automatic set_config(input logic [23:0] blend_word, input logic [23:0] mix_word,
                              input logic [23:0] prim, input logic [23:0] sec);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_BLEND_MODE;
        cfg_data  <= blend_word;
        @(posedge clk);
        cfg_index <= CFG_MIX_MODE;
        cfg_data  <= mix_word;
        @(posedge clk);
        cfg_index <= CFG_PRIMARY;
        cfg_data  <= prim;
        @(posedge clk);
        cfg_index <= CFG_SECONDARY;
        cfg_data  <= sec;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_blend     = blend_word[1:0];
        cur_mix       = mix_word[2:0];
        cur_primary   = prim;
        cur_secondary = sec;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Random pixel sources
    // ------------------------------------------------------------------------

    function automatic chan_t rand_chan();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return chan_t'($urandom);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     want;
        int     r;
        int     g;
        px = '0;
        case ($urandom_range(0, 15))
            0: px = '0;
            1: px = '1;
            2, 3:
            begin
                // channel sum right at the threshold boundary (382 or 383)
                want = 382 + $urandom_range(0, 1);
                r = $urandom_range(128, 255);
                g = $urandom_range(0, want - r);
                px[0] = chan_t'(r);
                px[1] = chan_t'(g);
                px[2] = chan_t'(want - r - g);
            end
            4, 5, 6, 7:
            begin
                px[0] = rand_chan();
                px[1] = rand_chan();
                px[2] = rand_chan();
            end
            default: px = pixel_t'($urandom);
        endcase
        return px;
    endfunction

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset configuration: no transform, replace
    task automatic test_reset_defaults();
        send_pixel(24'hFFFFFF, 24'h000000);
        send_pixel(24'h000000, 24'hFFFFFF);
        send_pixel(24'h123456, 24'h000001);
    endtask

    // Invert of zero stays zero, and replace keeps the target on zero
    task automatic test_invert_zero();
        set_config(24'(BLEND_INVERT), 24'(MIX_REPLACE), 24'h000000, 24'h000000);
        send_pixel(24'hA5A5A5, 24'h000000);
        send_pixel(24'h5A5A5A, 24'hFFFFFF);
        send_pixel(24'h000000, 24'h0000FF);
    endtask

    // Threshold on both sides of 2*sum = 765, and a zero source
    task automatic test_threshold_edges();
        set_config(24'(BLEND_THRESH), 24'(MIX_MAX), 24'h0000FF, 24'hFF0000);
        send_pixel(24'h102030, 24'h00FF7F);
        send_pixel(24'h102030, 24'h00FF80);
        send_pixel(24'h102030, 24'h000000);
    endtask

    // Lerp at zero, full scale, smallest weight and about a quarter weight
    task automatic test_lerp_edges();
        set_config(24'(BLEND_LERP), 24'(MIX_ADD), 24'h10FF00, 24'hF000FF);
        send_pixel(24'h808080, 24'h000000);
        send_pixel(24'h0000FF, 24'hFFFFFF);
        send_pixel(24'h7F7F7F, 24'h000001);
        send_pixel(24'hFFFFFF, 24'h404040);
    endtask

    // Every mix code but replace, the spare code included
    task automatic test_mix_modes();
        logic [2:0] codes [7];
        codes[0] = MIX_MAX;
        codes[1] = MIX_MIN;
        codes[2] = MIX_AVG;
        codes[3] = MIX_MUL;
        codes[4] = MIX_ADD;
        codes[5] = MIX_SUB;
        codes[6] = MIX_SPARE;
        for (int m = 0; m < 7; m++)
        begin
            set_config(24'(BLEND_NONE), 24'(codes[m]), 24'h000000, 24'h000000);
            send_pixel(24'hFF8000, 24'h80FF01);
        end
        send_pixel(24'h123456, 24'h000000);
    endtask

    // Random configurations, each with a burst of random pixels
    task automatic test_random_phases();
        logic [23:0] blend_word;
        logic [23:0] mix_word;
        logic [23:0] prim;
        logic [23:0] sec;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            blend_word = 24'($urandom_range(0, 3));
            mix_word   = 24'($urandom_range(0, 7));
            prim       = rand_color();
            sec        = rand_color();
            if (ph == 0)
            begin
                blend_word = 24'(BLEND_LERP);
                mix_word   = 24'(MIX_SPARE);
                prim       = 24'hFFFFFF;
                sec        = 24'h000000;
            end
            else if (ph == 1)
            begin
                blend_word = 24'(BLEND_THRESH);
                mix_word   = 24'(MIX_MUL);
                prim       = 24'h000000;
                sec        = 24'hFFFFFF;
            end
            // unused upper bits of the mode registers must be ignored
            if ($urandom_range(0, 3) == 0)
            begin
                blend_word = blend_word | (24'($urandom) & 24'hFFFFFC);
                mix_word   = mix_word | (24'($urandom) & 24'hFFFFF8);
            end
            set_config(blend_word, mix_word, prim, sec);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_BEATS; i++)
                send_pixel(rand_pixel(), rand_pixel());
            no_gaps = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_invert_zero();
        test_threshold_edges();
        test_lerp_edges();
        test_mix_modes();
        test_random_phases();

        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixels never returned", expected_pixels[0], '0);

        $display("Sent %0d pixel beats over %0d register settings, checked %0d results",
                 n_pixels, n_settings, n_checked);
        $display("Blend modes none/invert/threshold/lerp and all mix codes, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/lcbc_pkg.sv
sv/lcbc_mix.sv
sv/led_color_blend_compositor.sv
tb/tb_led_color_blend_compositor.sv
